// ===== sv/lwe_matrix_multiply_add_macros.svh =====
// assertion macros shared by the lwe matrix multiply-add rtl
// expects aclk and aresetn in the scope of each use
`ifndef LWE_MATRIX_MULTIPLY_ADD_MACROS_SVH
`define LWE_MATRIX_MULTIPLY_ADD_MACROS_SVH

// property must hold at every clock edge out of reset
`define LMMA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// expression must never be true out of reset
`define LMMA_ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(expr)) \
        else $error(msg);

`endif

// ===== sv/lmma_pkg.sv =====
// types, codes and constants for the lwe matrix multiply-add block
// no dependencies
package lmma_pkg;

    localparam int CMD_W    = 2;
    localparam int IDX_W    = 10;
    localparam int COL_W    = 3;
    localparam int WORD_W   = 16;
    localparam int IDX_CMP_W = 13;

    localparam int ACC_DEPTH         = 8;
    localparam int INNER_DIM_DEFAULT = 1024;
    localparam int OUT_COLS_DEFAULT  = 8;
    localparam int IDX_SPAN          = 2 ** IDX_W;
    localparam int QUEUE_DEPTH       = 4;

    localparam logic [CMD_W-1:0] CMD_SECRET = 2'd0;
    localparam logic [CMD_W-1:0] CMD_BIAS   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_MATRIX = 2'd2;

    typedef logic [WORD_W-1:0] word_t;

    typedef enum logic [1:0] {
        OP_SECRET,
        OP_BIAS,
        OP_MAC
    } op_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [IDX_W-1:0] inner_index;
        logic [COL_W-1:0] column;
        word_t            word;
        logic             row_end;
    } in_item_t;

    typedef struct packed {
        logic [COL_W-1:0] out_column;
        word_t            sum;
        logic             last;
    } out_item_t;

    typedef struct packed {
        op_t              op;
        logic             hit;
        logic             row_end;
        logic [IDX_W-1:0] idx;
        logic [COL_W-1:0] col;
        word_t            word;
    } queue_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// ===== sv/lmma_front.sv =====
// front end: accepts input transfers, classifies them and drops the ones with no effect
// depends on lmma_pkg
module lmma_front #(
    parameter int INNER_DIM = lmma_pkg::INNER_DIM_DEFAULT,
    parameter int OUT_COLS  = lmma_pkg::OUT_COLS_DEFAULT
) (
    input  logic                  s_valid,
    output logic                  s_ready,
    input  lmma_pkg::in_item_t    s_data,
    input  lmma_pkg::q_status_t   q_stat,
    output logic                  push,
    output lmma_pkg::queue_entry_t push_entry
);

    localparam int ACTIVE_COLS =
        (OUT_COLS < lmma_pkg::ACC_DEPTH) ? OUT_COLS : lmma_pkg::ACC_DEPTH;

    logic keep;
    logic hit;
    logic col_ok;

    assign hit    = (lmma_pkg::IDX_CMP_W'(s_data.inner_index)
                     < lmma_pkg::IDX_CMP_W'(INNER_DIM));
    assign col_ok = (4'(s_data.column) < 4'(ACTIVE_COLS));

    always_comb begin
        push_entry.op      = lmma_pkg::OP_MAC;
        push_entry.hit     = hit;
        push_entry.row_end = s_data.row_end;
        push_entry.idx     = s_data.inner_index;
        push_entry.col     = s_data.column;
        push_entry.word    = s_data.word;
        keep               = 1'b0;
        unique case (s_data.cmd)
            lmma_pkg::CMD_SECRET: begin
                push_entry.op = lmma_pkg::OP_SECRET;
                keep          = hit & col_ok;
            end
            lmma_pkg::CMD_BIAS: begin
                push_entry.op = lmma_pkg::OP_BIAS;
                keep          = col_ok;
            end
            lmma_pkg::CMD_MATRIX: begin
                push_entry.op = lmma_pkg::OP_MAC;
                keep          = 1'b1;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign s_ready = ~q_stat.full;
    assign push    = s_valid & s_ready & keep;

endmodule

// ===== sv/lmma_queue.sv =====
// short queue between the front end and the datapath
// depends on lmma_pkg and the assertion macro header
`include "lwe_matrix_multiply_add_macros.svh"
module lmma_queue (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  lmma_pkg::queue_entry_t push_entry,
    input  logic                   pop,
    output lmma_pkg::queue_entry_t head,
    output lmma_pkg::q_status_t    q_stat
);

    localparam int DEPTH = lmma_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    lmma_pkg::queue_entry_t entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

    assign head         = entry_reg[rd_ptr_reg];
    assign q_stat.full  = (count_reg == CNT_FULL);
    assign q_stat.empty = (count_reg == '0);

    `LMMA_ASSERT_NEVER(a_push_when_full, push && q_stat.full, "push into full queue")
    `LMMA_ASSERT_NEVER(a_pop_when_empty, pop && q_stat.empty, "pop from empty queue")
    `LMMA_ASSERT(a_count_up, (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1), "count lost a push")

endmodule

// ===== sv/lmma_back.sv =====
// datapath: secret banks, lane multipliers, accumulators and the result buffer
// depends on lmma_pkg and the assertion macro header
`include "lwe_matrix_multiply_add_macros.svh"
module lmma_back #(
    parameter int INNER_DIM = lmma_pkg::INNER_DIM_DEFAULT,
    parameter int OUT_COLS  = lmma_pkg::OUT_COLS_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  lmma_pkg::q_status_t    q_stat,
    input  lmma_pkg::queue_entry_t head,
    output logic                   pop,
    output logic                   m_valid,
    input  logic                   m_ready,
    output lmma_pkg::out_item_t    m_data
);

    localparam int ACTIVE_COLS =
        (OUT_COLS < lmma_pkg::ACC_DEPTH) ? OUT_COLS : lmma_pkg::ACC_DEPTH;
    localparam int STORE_ROWS =
        (INNER_DIM < lmma_pkg::IDX_SPAN) ? INNER_DIM : lmma_pkg::IDX_SPAN;
    localparam int ADDR_W = (STORE_ROWS > 1) ? $clog2(STORE_ROWS) : 1;
    localparam int CNT_W  = (ACTIVE_COLS > 1) ? $clog2(ACTIVE_COLS) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ACTIVE_COLS - 1);

    logic              adv;
    logic [ADDR_W-1:0] addr;
    lmma_pkg::word_t   rd_data [ACTIVE_COLS];

    logic                   p1_valid_reg;
    lmma_pkg::queue_entry_t p1_ent_reg;
    logic                   p2_valid_reg;
    lmma_pkg::queue_entry_t p2_ent_reg;
    lmma_pkg::word_t        prod_reg  [ACTIVE_COLS];
    lmma_pkg::word_t        prod_next [ACTIVE_COLS];
    logic [31:0]            prod_full [ACTIVE_COLS];

    lmma_pkg::word_t acc_reg  [ACTIVE_COLS];
    lmma_pkg::word_t acc_next [ACTIVE_COLS];
    lmma_pkg::word_t sum      [ACTIVE_COLS];

    lmma_pkg::word_t  out_buf_reg  [ACTIVE_COLS];
    lmma_pkg::word_t  out_buf_next [ACTIVE_COLS];
    logic [CNT_W-1:0] out_cnt_reg, out_cnt_next;
    logic             out_busy_reg, out_busy_next;

    logic emit;
    logic load;
    logic xfer;
    logic out_last;
    logic out_free;

    assign addr = head.idx[ADDR_W-1:0];
    assign pop  = adv & ~q_stat.empty;

    // one bank per column, written by secret loads, read ahead of the multiply
    for (genvar c = 0; c < ACTIVE_COLS; c++) begin : g_bank
        lmma_pkg::word_t bank_mem [STORE_ROWS];
        lmma_pkg::word_t rd_reg;

        always_ff @(posedge aclk) begin
            if (pop && head.op == lmma_pkg::OP_SECRET && head.col == 3'(c)) begin
                bank_mem[addr] <= head.word;
            end
            if (adv) begin
                rd_reg <= bank_mem[addr];
            end
        end

        assign rd_data[c] = rd_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
        end else if (adv) begin
            p1_valid_reg <= pop;
            p2_valid_reg <= p1_valid_reg;
        end
    end

    always_comb begin
        for (int c = 0; c < ACTIVE_COLS; c++) begin
            prod_full[c] = 32'(p1_ent_reg.word) * 32'(rd_data[c]);
            prod_next[c] = p1_ent_reg.hit ? prod_full[c][15:0] : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p1_ent_reg <= head;
            p2_ent_reg <= p1_ent_reg;
            prod_reg   <= prod_next;
        end
    end

    assign emit = p2_valid_reg & (p2_ent_reg.op == lmma_pkg::OP_MAC) & p2_ent_reg.row_end;
    assign out_last = (out_cnt_reg == CNT_LAST);
    assign xfer     = out_busy_reg & m_ready;
    assign out_free = ~out_busy_reg | (m_ready & out_last);
    assign adv      = ~(emit & ~out_free);
    assign load     = adv & emit;

    always_comb begin
        for (int c = 0; c < ACTIVE_COLS; c++) begin
            sum[c]      = acc_reg[c] + prod_reg[c];
            acc_next[c] = acc_reg[c];
            if (adv && p2_valid_reg) begin
                unique case (p2_ent_reg.op)
                    lmma_pkg::OP_BIAS: begin
                        if (p2_ent_reg.col == 3'(c)) begin
                            acc_next[c] = p2_ent_reg.word;
                        end
                    end
                    lmma_pkg::OP_MAC: begin
                        acc_next[c] = p2_ent_reg.row_end ? '0 : sum[c];
                    end
                    default: begin
                        acc_next[c] = acc_reg[c];
                    end
                endcase
            end
        end
    end

    always_comb begin
        out_busy_next = out_busy_reg;
        out_cnt_next  = out_cnt_reg;
        out_buf_next  = out_buf_reg;
        if (load) begin
            out_busy_next = 1'b1;
            out_cnt_next  = '0;
            out_buf_next  = sum;
        end else if (xfer) begin
            if (out_last) begin
                out_busy_next = 1'b0;
            end else begin
                out_cnt_next = out_cnt_reg + 1'b1;
            end
            for (int i = 0; i < ACTIVE_COLS - 1; i++) begin
                out_buf_next[i] = out_buf_reg[i + 1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_busy_reg <= 1'b0;
            out_cnt_reg  <= '0;
            for (int c = 0; c < ACTIVE_COLS; c++) begin
                acc_reg[c] <= '0;
            end
        end else begin
            out_busy_reg <= out_busy_next;
            out_cnt_reg  <= out_cnt_next;
            acc_reg      <= acc_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_buf_reg <= out_buf_next;
    end

    assign m_valid           = out_busy_reg;
    assign m_data.out_column = 3'(out_cnt_reg);
    assign m_data.sum        = out_buf_reg[0];
    assign m_data.last       = out_last;

    `LMMA_ASSERT(a_stall_needs_busy, !adv |-> out_busy_reg, "pipeline stalled with idle output")
    `LMMA_ASSERT(a_row_starts_col0, load |=> (out_busy_reg && out_cnt_reg == '0), "row did not start at column zero")
    `LMMA_ASSERT(a_acc_cleared, load |=> (acc_reg[0] == '0), "accumulators not cleared at row end")

endmodule

// ===== sv/lwe_matrix_multiply_add.sv =====
// top level of the lwe matrix multiply-add block, E + A*S modulo 2^16
// depends on lmma_pkg, lmma_front, lmma_queue and lmma_back
//
//   channel | ports                    | payload
//   input   | s_valid s_ready s_data   | cmd inner_index column word row_end
//   result  | m_valid m_ready m_data   | out_column sum last
//
// one input transfer per cycle while the four-entry queue has room
// row ends pass p1 and p2; sums then leave one per cycle while m_ready is high
// a row end waits while the result buffer still drains the previous row,
// so rows shorter than one element per active column run at that slower pace
// reset clears control and accumulators, the secret banks are not cleared
module lwe_matrix_multiply_add #(
    parameter int INNER_DIM = lmma_pkg::INNER_DIM_DEFAULT,
    parameter int OUT_COLS  = lmma_pkg::OUT_COLS_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  lmma_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output lmma_pkg::out_item_t m_data
);

    logic                   push;
    logic                   pop;
    lmma_pkg::queue_entry_t push_entry;
    lmma_pkg::queue_entry_t head;
    lmma_pkg::q_status_t    q_stat;

    lmma_front #(
        .INNER_DIM (INNER_DIM),
        .OUT_COLS  (OUT_COLS)
    ) u_front (
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .q_stat     (q_stat),
        .push       (push),
        .push_entry (push_entry)
    );

    lmma_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .q_stat     (q_stat)
    );

    lmma_back #(
        .INNER_DIM (INNER_DIM),
        .OUT_COLS  (OUT_COLS)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_stat  (q_stat),
        .head    (head),
        .pop     (pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
